// ----- hw/rtl/rgb_pixel_filter_with_edge_detect_assert.svh -----
// Assertion macros for the pixel filter checker
// Depends on nothing; included by the checker file
`ifndef RGB_PIXEL_FILTER_WITH_EDGE_DETECT_ASSERT_SVH
`define RGB_PIXEL_FILTER_WITH_EDGE_DETECT_ASSERT_SVH

// consequence in the cycle after a reset cycle, checked through reset
`define RPF_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!(rst_n)) |=> (cons)) else $error(msg);

// consequence in the cycle after the condition, off during reset
`define RPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rpf_pkg.sv -----
// Shared types and constants of the pixel filter
// No dependencies
`default_nettype none

package rpf_pkg;

    // one pixel, channel 0 red, 1 green, 2 blue
    localparam int CH_NUM = 3;
    typedef logic [7:0] chan_t;
    typedef logic [CH_NUM-1:0][7:0] pix_t;

    localparam chan_t CHAN_MAX = 8'd255;

    // filter_mode codes
    localparam logic [2:0] MODE_THRESH  = 3'd0;
    localparam logic [2:0] MODE_INVERT  = 3'd1;
    localparam logic [2:0] MODE_MERGE   = 3'd2;
    localparam logic [2:0] MODE_LIGHTEN = 3'd3;
    localparam logic [2:0] MODE_DARKEN  = 3'd4;
    localparam logic [2:0] MODE_EDGE    = 3'd5;

    // register indexes
    localparam logic [1:0] REG_FILTER_MODE     = 2'd0;
    localparam logic [1:0] REG_IMAGE_SIZE      = 2'd1;
    localparam logic [1:0] REG_LEVEL_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_EDGE_THRESHOLD  = 2'd3;

    // register reset values
    localparam logic [2:0] FILTER_MODE_RST     = MODE_THRESH;
    localparam logic [8:0] IMAGE_SIZE_RST      = 9'd256;
    localparam logic [7:0] LEVEL_THRESHOLD_RST = 8'd127;
    localparam logic [7:0] EDGE_THRESHOLD_RST  = 8'd50;

    // smallest usable image side
    localparam int MIN_SIZE = 2;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // operation the back applies to an item
    typedef enum logic [2:0] {
        OP_THRESH,
        OP_INVERT,
        OP_MERGE,
        OP_LIGHTEN,
        OP_DARKEN,
        OP_EDGE,
        OP_PASS
    } op_t;

    // classification of one item, set by the front
    typedef struct packed {
        op_t  op;
        logic emit_edge;   // edge result for the row above
        logic emit_pass;   // last row, pixel also goes out unchanged
        logic has_right;   // right neighbour exists in the row above
    } cls_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rpf_queue.sv -----
// Small register queue between the front and the back
// No package dependency
`default_nettype none

module rpf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rpf_front.sv -----
// Front of the pixel filter: takes pixels, tracks position, classifies
// Depends on rpf_pkg
`default_nettype none

module rpf_front
    import rpf_pkg::*;
#(
    parameter int MAX_SIZE = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [2:0]                    filter_mode,
    input  wire logic [8:0]                    image_size,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire pix_t                          s_cur,
    input  wire pix_t                          s_sec,
    input  wire logic                          s_frame_start,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output cls_t                               q_cls,
    output pix_t                               q_cur,
    output pix_t                               q_sec,
    output logic [$clog2(MAX_SIZE)-1:0]        q_row,
    output logic [$clog2(MAX_SIZE)-1:0]        q_col
);

    localparam int POS_W = $clog2(MAX_SIZE);
    localparam int SZ_W  = $clog2(MAX_SIZE + 1);
    localparam int CMP_W = (SZ_W > 9) ? SZ_W : 9;

    logic [POS_W-1:0] row_count_reg, row_count_next;
    logic [POS_W-1:0] col_count_reg, col_count_next;
    logic [CMP_W-1:0] img, eff_size;
    logic [POS_W-1:0] row0, col0, row, col;
    logic [CMP_W-1:0] row_inc, col_inc;
    logic             last_col, last_row, accept;
    op_t              op;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;

    // clamp the image side to the supported range
    always_comb begin
        img = CMP_W'(image_size);
        if (img < CMP_W'(MIN_SIZE)) begin
            eff_size = CMP_W'(MIN_SIZE);
        end else if (img > CMP_W'(MAX_SIZE)) begin
            eff_size = CMP_W'(MAX_SIZE);
        end else begin
            eff_size = img;
        end
    end

    // position of this pixel and of the next one
    always_comb begin
        row0     = s_frame_start ? '0 : row_count_reg;
        col0     = s_frame_start ? '0 : col_count_reg;
        col      = (CMP_W'(col0) >= eff_size) ? '0 : col0;
        row      = (CMP_W'(row0) >= eff_size) ? '0 : row0;
        col_inc  = CMP_W'(col) + 1'b1;
        row_inc  = CMP_W'(row) + 1'b1;
        last_col = (col_inc >= eff_size);
        last_row = (row_inc == eff_size);
        if (last_col) begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : POS_W'(row_inc);
        end else begin
            col_count_next = POS_W'(col_inc);
            row_count_next = row;
        end
    end

    // mode to operation
    always_comb begin
        unique case (filter_mode)
            MODE_THRESH:  op = OP_THRESH;
            MODE_INVERT:  op = OP_INVERT;
            MODE_MERGE:   op = OP_MERGE;
            MODE_LIGHTEN: op = OP_LIGHTEN;
            MODE_DARKEN:  op = OP_DARKEN;
            MODE_EDGE:    op = OP_EDGE;
            default:      op = OP_PASS;
        endcase
    end

    // queue entry
    always_comb begin
        q_cls.op        = op;
        q_cls.emit_edge = (op == OP_EDGE) && (row != '0);
        q_cls.emit_pass = (op == OP_EDGE) && last_row;
        q_cls.has_right = !last_col;
        q_cur           = s_cur;
        q_sec           = s_sec;
        q_row           = row;
        q_col           = col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (accept) begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rpf_back.sv -----
// Back of the pixel filter: line buffer, filter arithmetic, result register
// Depends on rpf_pkg
`default_nettype none

module rpf_back
    import rpf_pkg::*;
#(
    parameter int MAX_SIZE = 256,
    parameter int CHANNELS = 3
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [7:0]                  level_threshold,
    input  wire logic [7:0]                  edge_threshold,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire cls_t                        q_cls,
    input  wire pix_t                        q_cur,
    input  wire pix_t                        q_sec,
    input  wire logic [$clog2(MAX_SIZE)-1:0] q_row,
    input  wire logic [$clog2(MAX_SIZE)-1:0] q_col,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pix_t                             m_pix,
    output logic [7:0]                       m_row,
    output logic [7:0]                       m_col
);

    localparam int POS_W  = $clog2(MAX_SIZE);
    localparam int MEM_CH = (CHANNELS < CH_NUM) ? CHANNELS : CH_NUM;
    localparam int MEM_W  = MEM_CH * 8;

    // line buffer: previous row, one write and two reads per item
    logic [MEM_W-1:0] line_mem [MAX_SIZE];
    logic [MEM_W-1:0] rd0_reg, rd1_reg;
    logic [POS_W-1:0] right_addr;

    // stage b: item with its line buffer data
    logic             b_valid_reg, b_valid_next;
    logic             phase_reg, phase_next;
    cls_t             b_cls_reg;
    pix_t             b_cur_reg, b_sec_reg;
    logic [POS_W-1:0] b_row_reg, b_col_reg;

    // result register
    logic             out_valid_reg;
    pix_t             out_pix_reg;
    logic [7:0]       out_row_reg, out_col_reg;

    logic             want_edge, is_edge, has_out, slot_free, out_load, b_done, b_free;
    pix_t             here_pix, right_pix, edge_pix, point_pix, sel_pix;
    logic [7:0]       sel_row;

    function automatic chan_t absdiff(input chan_t a, input chan_t b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    function automatic chan_t point_op(input op_t op, input chan_t x, input chan_t y,
                                       input chan_t lvl);
        logic [8:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        unique case (op)
            OP_THRESH:  point_op = (x > lvl) ? CHAN_MAX : '0;
            OP_INVERT:  point_op = CHAN_MAX - x;
            OP_MERGE:   point_op = sum[8:1];
            OP_LIGHTEN: point_op = x + ((CHAN_MAX - x) >> 1);
            OP_DARKEN:  point_op = x - (x >> 1);
            default:    point_op = x;
        endcase
    endfunction

    assign q_pop      = q_valid && b_free;
    assign right_addr = (q_col == POS_W'(MAX_SIZE - 1)) ? '0 : q_col + 1'b1;

    // read old row at this column and the next, then store this pixel
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd0_reg           <= line_mem[q_col];
            rd1_reg           <= line_mem[right_addr];
            line_mem[q_col]   <= q_cur[MEM_CH-1:0];
        end
    end

    // channels without storage read as zero
    always_comb begin
        here_pix                  = '0;
        right_pix                 = '0;
        here_pix[MEM_CH-1:0]      = rd0_reg;
        right_pix[MEM_CH-1:0]     = rd1_reg;
    end

    // per channel edge and point results
    always_comb begin
        for (int k = 0; k < CH_NUM; k++) begin
            logic edge_hit;
            edge_hit = (absdiff(here_pix[k], b_cur_reg[k]) >= edge_threshold)
                    || (b_cls_reg.has_right
                        && (absdiff(here_pix[k], right_pix[k]) >= edge_threshold));
            edge_pix[k]  = edge_hit ? '0 : CHAN_MAX;
            point_pix[k] = point_op(b_cls_reg.op, b_cur_reg[k], b_sec_reg[k],
                                    level_threshold);
        end
    end

    // result sequencing: where an item gives both, edge result first, then the unchanged pixel
    always_comb begin
        is_edge   = (b_cls_reg.op == OP_EDGE);
        want_edge = b_cls_reg.emit_edge && !phase_reg;
        has_out   = b_valid_reg && (!is_edge || want_edge || b_cls_reg.emit_pass);
        slot_free = !out_valid_reg || m_ready;
        out_load  = has_out && slot_free;
        b_done    = b_valid_reg
                 && (!has_out || (slot_free && !(want_edge && b_cls_reg.emit_pass)));
        b_free    = !b_valid_reg || b_done;

        phase_next = phase_reg;
        if (b_done) begin
            phase_next = 1'b0;
        end else if (out_load) begin
            phase_next = 1'b1;
        end
        b_valid_next = q_pop ? 1'b1 : (b_done ? 1'b0 : b_valid_reg);

        if (want_edge) begin
            sel_pix = edge_pix;
            sel_row = 8'(b_row_reg - POS_W'(1));
        end else begin
            sel_pix = is_edge ? b_cur_reg : point_pix;
            sel_row = 8'(b_row_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            phase_reg     <= phase_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_cls_reg <= q_cls;
            b_cur_reg <= q_cur;
            b_sec_reg <= q_sec;
            b_row_reg <= q_row;
            b_col_reg <= q_col;
        end
        if (out_load) begin
            out_pix_reg <= sel_pix;
            out_row_reg <= sel_row;
            out_col_reg <= 8'(b_col_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pix   = out_pix_reg;
    assign m_row   = out_row_reg;
    assign m_col   = out_col_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_pixel_filter_with_edge_detect.sv -----
// Top level of the RGB pixel filter with edge detection
// Depends on rpf_pkg, rpf_front, rpf_queue and rpf_back
`default_nettype none

// Streaming RGB filter for square images sent in raster order. One pixel is
// accepted per clock in every mode while the queue has room; edge mode on the
// last row of the image gives two results per pixel (the edge result for the
// row above and the pixel itself), so there the result register sets the
// pace. An accepted pixel is written into the queue, then read out of it
// together with its line buffer data into stage b, then loaded into the
// result register. A four-entry queue separates the position tracking front
// from the back, which holds the line buffer (one MAX_SIZE-entry memory, one
// write and two reads per pixel). The line buffer is not cleared after reset;
// an edge result for a row whose upper row was never sent is undefined. Write
// configuration only while no item is in flight.

module rgb_pixel_filter_with_edge_detect
    import rpf_pkg::*;
#(
    parameter int MAX_SIZE = 256,
    parameter int CHANNELS = 3
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    // pixel input
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_red,
    input  wire logic [7:0] s_green,
    input  wire logic [7:0] s_blue,
    input  wire logic [7:0] s_second_red,
    input  wire logic [7:0] s_second_green,
    input  wire logic [7:0] s_second_blue,
    input  wire logic       s_frame_start,
    // result output
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_red,
    output logic [7:0]      m_out_green,
    output logic [7:0]      m_out_blue,
    output logic [7:0]      m_out_row,
    output logic [7:0]      m_out_col
);

    localparam int POS_W   = $clog2(MAX_SIZE);
    localparam int ENTRY_W = $bits(cls_t) + 2 * $bits(pix_t) + 2 * POS_W;

    logic [2:0]       filter_mode_reg;
    logic [8:0]       image_size_reg;
    logic [7:0]       level_threshold_reg;
    logic [7:0]       edge_threshold_reg;

    pix_t             s_cur, s_sec, m_pix;
    logic             f_push, f_ready, q_valid, q_pop;
    cls_t             f_cls, q_cls;
    pix_t             f_cur, f_sec, q_cur, q_sec;
    logic [POS_W-1:0] f_row, f_col, q_row, q_col;
    logic [ENTRY_W-1:0] f_entry, q_entry;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg     <= FILTER_MODE_RST;
            image_size_reg      <= IMAGE_SIZE_RST;
            level_threshold_reg <= LEVEL_THRESHOLD_RST;
            edge_threshold_reg  <= EDGE_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FILTER_MODE:     filter_mode_reg     <= cfg_data[2:0];
                REG_IMAGE_SIZE:      image_size_reg      <= cfg_data;
                REG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data[7:0];
                REG_EDGE_THRESHOLD:  edge_threshold_reg  <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // pixel packing
    assign s_cur = {s_blue, s_green, s_red};
    assign s_sec = {s_second_blue, s_second_green, s_second_red};

    rpf_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .filter_mode   (filter_mode_reg),
        .image_size    (image_size_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cur         (s_cur),
        .s_sec         (s_sec),
        .s_frame_start (s_frame_start),
        .q_ready       (f_ready),
        .q_push        (f_push),
        .q_cls         (f_cls),
        .q_cur         (f_cur),
        .q_sec         (f_sec),
        .q_row         (f_row),
        .q_col         (f_col)
    );

    assign f_entry = {f_cls, f_cur, f_sec, f_row, f_col};
    assign {q_cls, q_cur, q_sec, q_row, q_col} = q_entry;

    rpf_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_push),
        .in_ready  (f_ready),
        .in_data   (f_entry),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_data  (q_entry)
    );

    rpf_back #(
        .MAX_SIZE (MAX_SIZE),
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .level_threshold (level_threshold_reg),
        .edge_threshold  (edge_threshold_reg),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_cls           (q_cls),
        .q_cur           (q_cur),
        .q_sec           (q_sec),
        .q_row           (q_row),
        .q_col           (q_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pix           (m_pix),
        .m_row           (m_out_row),
        .m_col           (m_out_col)
    );

    // result unpacking
    assign m_out_red   = m_pix[0];
    assign m_out_green = m_pix[1];
    assign m_out_blue  = m_pix[2];

endmodule

`default_nettype wire

// ----- hw/rtl/rpf_checker.sv -----
// Port-level checks for the pixel filter, bound to its top level
// Depends on rgb_pixel_filter_with_edge_detect_assert.svh
`default_nettype none

`include "rgb_pixel_filter_with_edge_detect_assert.svh"

module rpf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_red,
    input wire logic [7:0] m_out_green,
    input wire logic [7:0] m_out_blue,
    input wire logic [7:0] m_out_row,
    input wire logic [7:0] m_out_col
);

    logic [39:0] m_payload;
    logic        m_stall;

    assign m_payload = {m_out_red, m_out_green, m_out_blue, m_out_row, m_out_col};
    assign m_stall   = m_valid && !m_ready;

    // reset empties the result register and the queue
    `RPF_ASSERT_RST(a_rst_no_result, aclk, aresetn, !m_valid, "result valid after reset")
    `RPF_ASSERT_RST(a_rst_in_ready, aclk, aresetn, s_ready, "input not ready after reset")

    // a stalled result stays and holds its payload
    `RPF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_stall, m_valid, "stalled result dropped")
    `RPF_ASSERT_NXT(a_out_stable, aclk, aresetn, m_stall, $stable(m_payload), "stalled result changed")

endmodule

bind rgb_pixel_filter_with_edge_detect rpf_checker u_rpf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_red   (m_out_red),
    .m_out_green (m_out_green),
    .m_out_blue  (m_out_blue),
    .m_out_row   (m_out_row),
    .m_out_col   (m_out_col)
);

`default_nettype wire
